// File: src/plotter_staircase_step_generator_macros.svh
// Assertion macros used by the plotter step generator controller.
`ifndef PLOTTER_STAIRCASE_STEP_GENERATOR_MACROS_SVH
`define PLOTTER_STAIRCASE_STEP_GENERATOR_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define PSSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond at one edge leads to res at the next edge.
`define PSSG_ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

// File: src/pssg_pkg.sv
// Shared types and constants for the plotter staircase step generator.
`timescale 1ns / 1ps
`default_nettype none

package pssg_pkg;

  localparam int COORD_BITS_DEF = 8;

  localparam logic [1:0] FN_TICK  = 2'd0;
  localparam logic [1:0] FN_MOVE  = 2'd1;
  localparam logic [1:0] FN_LINE  = 2'd2;
  localparam logic [1:0] FN_PIXEL = 2'd3;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_MOVE_X = 6'b000010,
    PH_MOVE_Y = 6'b000100,
    PH_PEN    = 6'b001000,
    PH_MAJOR  = 6'b010000,
    PH_MINOR  = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_PIXEL = 2'd2
  } kind_t;

  typedef struct packed {
    logic   accept;
    logic   step;
    logic   latch;
    kind_t  kind;
    logic   reload;
    phase_t phase;
  } pssg_cmd_t;

  typedef struct packed {
    logic x_eq;
    logic y_eq;
    logic steps_zero;
    logic stairs_one;
    logic kind_line;
    logic kind_pixel;
  } pssg_stat_t;

endpackage

`default_nettype wire

// File: src/pssg_div.sv
// Restoring divider, one quotient bit per cycle, for the stair length.
`timescale 1ns / 1ps
`default_nettype none

module pssg_div #(
  parameter int COORD_BITS = pssg_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [COORD_BITS-1:0] dividend,
  input  wire logic [COORD_BITS:0]   divisor,
  output logic                       done,
  output logic [COORD_BITS-1:0]      quotient
);

  localparam int CNT_W = $clog2(COORD_BITS + 1);

  logic [COORD_BITS-1:0] quo_r, quo_nxt;
  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [COORD_BITS:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [COORD_BITS:0]   trial;
  logic                  ge;

  always_comb begin
    trial    = {rem_r[COORD_BITS-1:0], quo_r[COORD_BITS-1]};
    ge       = (trial >= dvs_r);
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(COORD_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? (trial - dvs_r) : trial;
      quo_nxt = {quo_r[COORD_BITS-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: src/pssg_dp.sv
// Datapath: positions, targets, stair counters, pulse and color registers.
`timescale 1ns / 1ps
`default_nettype none

module pssg_dp #(
  parameter int COORD_BITS = pssg_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pssg_pkg::pssg_cmd_t   cmd,
  output pssg_pkg::pssg_stat_t       stat,
  input  wire logic [COORD_BITS-1:0] in_x_a,
  input  wire logic [COORD_BITS-1:0] in_y_a,
  input  wire logic [COORD_BITS-1:0] in_x_b,
  input  wire logic [COORD_BITS-1:0] in_y_b,
  input  wire logic [1:0]            in_pen_color,
  input  wire logic [COORD_BITS-1:0] stair_length,
  output logic [COORD_BITS-1:0]      div_dividend,
  output logic [COORD_BITS:0]        div_divisor,
  output logic                       out_x_up_pulse,
  output logic                       out_x_down_pulse,
  output logic                       out_y_up_pulse,
  output logic                       out_y_down_pulse,
  output logic                       out_pen_down,
  output logic [1:0]                 out_color_pins
);

  logic [COORD_BITS-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [COORD_BITS:0]   stairs_r, stairs_nxt;
  logic [COORD_BITS-1:0] steps_r, steps_nxt;
  logic                  ymaj_r, ymaj_nxt, ydesc_r, ydesc_nxt;
  pssg_pkg::kind_t       kind_r, kind_nxt;
  logic [1:0]            pix_r, pix_nxt, color_r, color_nxt;
  logic                  xu_r, xd_r, yu_r, yd_r, pen_r;
  logic                  xu, xd, yu, yd, pen;
  logic [COORD_BITS-1:0] dx, dy, minor;
  logic                  ymaj_in;

  always_comb begin
    dx           = (in_x_a > in_x_b) ? (in_x_a - in_x_b) : (in_x_b - in_x_a);
    dy           = (in_y_a > in_y_b) ? (in_y_a - in_y_b) : (in_y_b - in_y_a);
    ymaj_in      = (dx <= dy);
    minor        = ymaj_in ? dx : dy;
    div_dividend = ymaj_in ? dy : dx;
    div_divisor  = {1'b0, minor} + (COORD_BITS+1)'(1);
  end

  always_comb begin
    xu  = 1'b0;
    xd  = 1'b0;
    yu  = 1'b0;
    yd  = 1'b0;
    pen = 1'b0;
    if (cmd.step) begin
      case (cmd.phase)
        pssg_pkg::PH_MOVE_X: begin
          xu = (tgt_x_r > pos_x_r);
          xd = !(tgt_x_r > pos_x_r);
        end
        pssg_pkg::PH_MOVE_Y: begin
          yu = (tgt_y_r > pos_y_r);
          yd = !(tgt_y_r > pos_y_r);
        end
        pssg_pkg::PH_PEN: begin
          pen = 1'b1;
        end
        pssg_pkg::PH_MAJOR: begin
          pen = 1'b1;
          xu  = !ymaj_r;
          yu  = ymaj_r && !ydesc_r;
          yd  = ymaj_r && ydesc_r;
        end
        pssg_pkg::PH_MINOR: begin
          xu = ymaj_r;
          yu = !ymaj_r && !ydesc_r;
          yd = !ymaj_r && ydesc_r;
        end
        default: begin
          pen = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    pos_x_nxt  = xu ? (pos_x_r + COORD_BITS'(1)) : (xd ? (pos_x_r - COORD_BITS'(1)) : pos_x_r);
    pos_y_nxt  = yu ? (pos_y_r + COORD_BITS'(1)) : (yd ? (pos_y_r - COORD_BITS'(1)) : pos_y_r);
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    stairs_nxt = stairs_r;
    steps_nxt  = steps_r;
    ymaj_nxt   = ymaj_r;
    ydesc_nxt  = ydesc_r;
    kind_nxt   = kind_r;
    pix_nxt    = pix_r;
    color_nxt  = color_r;
    if (cmd.latch) begin
      tgt_x_nxt = in_x_a;
      tgt_y_nxt = in_y_a;
      kind_nxt  = cmd.kind;
      if (cmd.kind == pssg_pkg::KIND_PIXEL) begin
        pix_nxt = in_pen_color;
      end
      if (cmd.kind == pssg_pkg::KIND_LINE) begin
        ymaj_nxt   = ymaj_in;
        ydesc_nxt  = (in_y_a > in_y_b);
        stairs_nxt = {1'b0, minor} + (COORD_BITS+1)'(1);
      end
    end
    if (cmd.step && cmd.phase == pssg_pkg::PH_PEN) begin
      color_nxt = pix_r;
    end
    if (cmd.step && cmd.phase == pssg_pkg::PH_MAJOR) begin
      steps_nxt = steps_r - COORD_BITS'(1);
    end
    if (cmd.step && cmd.phase == pssg_pkg::PH_MINOR) begin
      stairs_nxt = stairs_r - (COORD_BITS+1)'(1);
    end
    if (cmd.reload) begin
      steps_nxt = stair_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      stairs_r <= '0;
      steps_r  <= '0;
      ymaj_r   <= 1'b0;
      ydesc_r  <= 1'b0;
      kind_r   <= pssg_pkg::KIND_NONE;
      pix_r    <= 2'd0;
      color_r  <= 2'd0;
      xu_r     <= 1'b0;
      xd_r     <= 1'b0;
      yu_r     <= 1'b0;
      yd_r     <= 1'b0;
      pen_r    <= 1'b0;
    end else begin
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      stairs_r <= stairs_nxt;
      steps_r  <= steps_nxt;
      ymaj_r   <= ymaj_nxt;
      ydesc_r  <= ydesc_nxt;
      kind_r   <= kind_nxt;
      pix_r    <= pix_nxt;
      color_r  <= color_nxt;
      if (cmd.accept) begin
        xu_r  <= xu;
        xd_r  <= xd;
        yu_r  <= yu;
        yd_r  <= yd;
        pen_r <= pen;
      end
    end
  end

  always_comb begin
    stat.x_eq       = (pos_x_r == tgt_x_r);
    stat.y_eq       = (pos_y_r == tgt_y_r);
    stat.steps_zero = (steps_r == '0);
    stat.stairs_one = (stairs_r == (COORD_BITS+1)'(1));
    stat.kind_line  = (kind_r == pssg_pkg::KIND_LINE);
    stat.kind_pixel = (kind_r == pssg_pkg::KIND_PIXEL);
  end

  assign out_x_up_pulse   = xu_r;
  assign out_x_down_pulse = xd_r;
  assign out_y_up_pulse   = yu_r;
  assign out_y_down_pulse = yd_r;
  assign out_pen_down     = pen_r;
  assign out_color_pins   = color_r;

endmodule

`default_nettype wire

// File: src/pssg_ctrl.sv
// Controller: request handshake, plotting phase and settle sequencing.
`timescale 1ns / 1ps
`default_nettype none

module pssg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_func,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_busy_res,
  output logic                      out_cmd_done,
  output logic                      out_rejected,
  output pssg_pkg::pssg_cmd_t       cmd,
  input  wire pssg_pkg::pssg_stat_t stat,
  input  wire logic                 div_done
);

  `include "plotter_staircase_step_generator_macros.svh"

  typedef enum logic [3:0] {
    C_IDLE   = 4'b0001,
    C_DIV    = 4'b0010,
    C_SETTLE = 4'b0100,
    C_RESP   = 4'b1000
  } ctl_state_t;

  ctl_state_t       st_r, st_nxt;
  pssg_pkg::phase_t phase_r, phase_nxt;
  logic             done_r, done_nxt, rej_r, rej_nxt;
  logic             in_acc, busy, is_cmd;

  assign in_acc = in_valid && (st_r == C_IDLE);
  assign busy   = (phase_r != pssg_pkg::PH_IDLE);
  assign is_cmd = (in_func != pssg_pkg::FN_TICK);

  always_comb begin
    st_nxt     = st_r;
    phase_nxt  = phase_r;
    done_nxt   = done_r;
    rej_nxt    = rej_r;
    cmd.accept = in_acc;
    cmd.step   = 1'b0;
    cmd.latch  = 1'b0;
    cmd.kind   = pssg_pkg::KIND_NONE;
    cmd.reload = 1'b0;
    cmd.phase  = phase_r;
    if (in_func == pssg_pkg::FN_LINE) begin
      cmd.kind = pssg_pkg::KIND_LINE;
    end else if (in_func == pssg_pkg::FN_PIXEL) begin
      cmd.kind = pssg_pkg::KIND_PIXEL;
    end
    case (st_r)
      C_IDLE: begin
        if (in_acc) begin
          done_nxt = 1'b0;
          rej_nxt  = 1'b0;
          if (is_cmd && busy) begin
            rej_nxt = 1'b1;
            st_nxt  = C_RESP;
          end else if (is_cmd) begin
            cmd.latch = 1'b1;
            if (in_func == pssg_pkg::FN_LINE) begin
              st_nxt = C_DIV;
            end else begin
              phase_nxt = pssg_pkg::PH_MOVE_X;
              st_nxt    = C_SETTLE;
            end
          end else if (busy) begin
            cmd.step = 1'b1;
            st_nxt   = C_SETTLE;
            case (phase_r)
              pssg_pkg::PH_PEN: begin
                phase_nxt = pssg_pkg::PH_IDLE;
              end
              pssg_pkg::PH_MINOR: begin
                if (stat.stairs_one) begin
                  phase_nxt = pssg_pkg::PH_IDLE;
                end else begin
                  phase_nxt  = pssg_pkg::PH_MAJOR;
                  cmd.reload = 1'b1;
                end
              end
              default: begin
                phase_nxt = phase_r;
              end
            endcase
          end else begin
            st_nxt = C_RESP;
          end
        end
      end
      C_DIV: begin
        if (div_done) begin
          phase_nxt = pssg_pkg::PH_MOVE_X;
          st_nxt    = C_SETTLE;
        end
      end
      C_SETTLE: begin
        case (phase_r)
          pssg_pkg::PH_MOVE_X: begin
            if (stat.x_eq) begin
              phase_nxt = pssg_pkg::PH_MOVE_Y;
            end else begin
              st_nxt = C_RESP;
            end
          end
          pssg_pkg::PH_MOVE_Y: begin
            if (!stat.y_eq) begin
              st_nxt = C_RESP;
            end else if (stat.kind_pixel) begin
              phase_nxt = pssg_pkg::PH_PEN;
            end else if (stat.kind_line) begin
              phase_nxt  = pssg_pkg::PH_MAJOR;
              cmd.reload = 1'b1;
            end else begin
              phase_nxt = pssg_pkg::PH_IDLE;
            end
          end
          pssg_pkg::PH_MAJOR: begin
            if (stat.steps_zero) begin
              phase_nxt = pssg_pkg::PH_MINOR;
            end else begin
              st_nxt = C_RESP;
            end
          end
          pssg_pkg::PH_PEN, pssg_pkg::PH_MINOR: begin
            st_nxt = C_RESP;
          end
          default: begin
            phase_nxt = pssg_pkg::PH_IDLE;
            done_nxt  = 1'b1;
            st_nxt    = C_RESP;
          end
        endcase
      end
      C_RESP: begin
        if (!out_stall) begin
          st_nxt = C_IDLE;
        end
      end
      default: begin
        st_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= C_IDLE;
      phase_r <= pssg_pkg::PH_IDLE;
      done_r  <= 1'b0;
      rej_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      rej_r   <= rej_nxt;
    end
  end

  assign in_stall     = (st_r != C_IDLE);
  assign out_valid    = (st_r == C_RESP);
  assign out_busy_res = busy;
  assign out_cmd_done = done_r;
  assign out_rejected = rej_r;

  `PSSG_ASSERT(a_rej_busy, (out_valid && rej_r) |-> busy, "rejected request while idle")
  `PSSG_ASSERT(a_done_idle, (out_valid && done_r) |-> !busy, "done reported while busy")
  `PSSG_ASSERT(a_step_busy, cmd.step |-> busy, "step issued in idle phase")
  `PSSG_ASSERT_NEXT(a_resp_ret, out_valid && !out_stall, !in_stall, "no return to idle")

endmodule

`default_nettype wire

// File: src/plotter_staircase_step_generator.sv
// Top level: plotter staircase step generator, one result per request.
// A tick in idle or a rejected command goes straight to its result; a tick, move
// or pixel passes the settle state first; a line command also waits for the divider.
// The next request is taken the cycle after its result is taken; until then in_stall
// holds off requests while the settle sequencer and stair-length divider work.
// Reset (rst_n low, synchronous): positions, color and counters clear, phase idle.
`timescale 1ns / 1ps
`default_nettype none

module plotter_staircase_step_generator #(
  parameter int COORD_BITS = pssg_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_func,
  input  wire logic [COORD_BITS-1:0] in_x_a,
  input  wire logic [COORD_BITS-1:0] in_y_a,
  input  wire logic [COORD_BITS-1:0] in_x_b,
  input  wire logic [COORD_BITS-1:0] in_y_b,
  input  wire logic [1:0]            in_pen_color,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_x_up_pulse,
  output logic                       out_x_down_pulse,
  output logic                       out_y_up_pulse,
  output logic                       out_y_down_pulse,
  output logic                       out_pen_down,
  output logic [1:0]                 out_color_pins,
  output logic                       out_busy_res,
  output logic                       out_cmd_done,
  output logic                       out_rejected
);

  pssg_pkg::pssg_cmd_t   cmd;
  pssg_pkg::pssg_stat_t  stat;
  logic                  div_done;
  logic [COORD_BITS-1:0] div_dividend, div_quotient;
  logic [COORD_BITS:0]   div_divisor;

  pssg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_func      (in_func),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_busy_res (out_busy_res),
    .out_cmd_done (out_cmd_done),
    .out_rejected (out_rejected),
    .cmd          (cmd),
    .stat         (stat),
    .div_done     (div_done)
  );

  pssg_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_x_a           (in_x_a),
    .in_y_a           (in_y_a),
    .in_x_b           (in_x_b),
    .in_y_b           (in_y_b),
    .in_pen_color     (in_pen_color),
    .stair_length     (div_quotient),
    .div_dividend     (div_dividend),
    .div_divisor      (div_divisor),
    .out_x_up_pulse   (out_x_up_pulse),
    .out_x_down_pulse (out_x_down_pulse),
    .out_y_up_pulse   (out_y_up_pulse),
    .out_y_down_pulse (out_y_down_pulse),
    .out_pen_down     (out_pen_down),
    .out_color_pins   (out_color_pins)
  );

  pssg_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.latch && (cmd.kind == pssg_pkg::KIND_LINE)),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

`default_nettype wire
